[sv/eslcg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entropy-seeded LCG generator package
// Shared types, constants and MD4 step tables for the generator blocks.
// ----------------------------------------------------------------------------
package eslcg_pkg;

  localparam int POOL_WORDS = 16;
  localparam int POOL_BYTES = 64;

  typedef logic [1:0]  op_t;
  typedef logic [5:0]  step_t;
  typedef logic [3:0]  word_idx_t;
  typedef logic [5:0]  byte_idx_t;
  typedef logic [31:0] word_t;

  localparam op_t OP_ADD_ENTROPY = 2'd0;
  localparam op_t OP_RESEED      = 2'd1;
  localparam op_t OP_NEXT        = 2'd2;

  localparam word_t MD4_INIT_A = 32'h6745_2301;
  localparam word_t MD4_INIT_B = 32'hefcd_ab89;
  localparam word_t MD4_INIT_C = 32'h98ba_dcfe;
  localparam word_t MD4_INIT_D = 32'h1032_5476;
  localparam word_t MD4_K2     = 32'h5a82_7999;
  localparam word_t MD4_K3     = 32'h6ed9_eba1;
  localparam word_t LCG_MUL    = 32'd1664525;
  localparam word_t LCG_ADD    = 32'd1013904223;

  localparam step_t LAST_STEP = 6'd47;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic  load;
    logic  advance;
    step_t step;
  } md4_ctrl_t;

  function automatic word_idx_t msg_index(input step_t s);
    word_idx_t j;
    word_idx_t k;
    j = s[3:0];
    case (s[5:4])
      2'd0: k = j;
      2'd1: k = {j[1:0], j[3:2]};
      2'd2: k = {j[0], j[1], j[2], j[3]};
      default: k = j;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] shift_amt(input step_t s);
    logic [4:0] r;
    case ({s[5:4], s[1:0]})
      4'b00_00: r = 5'd3;
      4'b00_01: r = 5'd7;
      4'b00_10: r = 5'd11;
      4'b00_11: r = 5'd19;
      4'b01_00: r = 5'd3;
      4'b01_01: r = 5'd5;
      4'b01_10: r = 5'd9;
      4'b01_11: r = 5'd13;
      4'b10_00: r = 5'd3;
      4'b10_01: r = 5'd9;
      4'b10_10: r = 5'd11;
      4'b10_11: r = 5'd15;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic word_t round_const(input logic [1:0] rnd);
    word_t k;
    case (rnd)
      2'd1: k = MD4_K2;
      2'd2: k = MD4_K3;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t round_func(input logic [1:0] rnd, input word_t b,
                                       input word_t c, input word_t d);
    word_t f;
    case (rnd)
      2'd0: f = d ^ (b & (c ^ d));
      2'd1: f = (b & c) | (b & d) | (c & d);
      2'd2: f = b ^ c ^ d;
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic word_t rotl32(input word_t x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

[sv/eslcg_pool.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entropy pool
// Sixteen little-endian 32-bit words written one byte a beat at a wrapping
// index, with one word read port for the hash sequencer.
// ----------------------------------------------------------------------------
module eslcg_pool
  import eslcg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  logic [7:0] wr_byte,
  input  word_idx_t rd_idx,
  output word_t     rd_word
);

  word_t     pool_r   [POOL_WORDS];
  word_t     pool_nxt [POOL_WORDS];
  byte_idx_t wr_idx_r;
  byte_idx_t wr_idx_nxt;

  always_comb begin
    pool_nxt   = pool_r;
    wr_idx_nxt = wr_idx_r;
    if (wr_en) begin
      pool_nxt[wr_idx_r[5:2]][{wr_idx_r[1:0], 3'b000} +: 8] = wr_byte;
      wr_idx_nxt = wr_idx_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL_WORDS; i++) begin
        pool_r[i] <= '0;
      end
      wr_idx_r <= '0;
    end else begin
      pool_r   <= pool_nxt;
      wr_idx_r <= wr_idx_nxt;
    end
  end

  assign rd_word = pool_r[rd_idx];

endmodule

[sv/eslcg_md4_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 step unit
// Holds the rotating digest words and performs one MD4 step per cycle.
// The message word plus round constant for the next step is fetched ahead.
// ----------------------------------------------------------------------------
module eslcg_md4_unit
  import eslcg_pkg::*;
(
  input  logic      clk,
  input  md4_ctrl_t ctrl,
  input  word_t     pool_word,
  output word_idx_t rd_idx,
  output word_t     hash_a
);

  word_t a_r, b_r, c_r, d_r, wk_r;
  word_t a_nxt, b_nxt, c_nxt, d_nxt, wk_nxt;
  step_t next_step;
  word_t sum;
  word_t a_new;

  assign next_step = ctrl.load ? '0 : ctrl.step + 6'd1;
  assign rd_idx    = msg_index(next_step);

  assign sum   = a_r + round_func(ctrl.step[5:4], b_r, c_r, d_r) + wk_r;
  assign a_new = rotl32(sum, shift_amt(ctrl.step));

  always_comb begin
    a_nxt  = a_r;
    b_nxt  = b_r;
    c_nxt  = c_r;
    d_nxt  = d_r;
    wk_nxt = wk_r;
    if (ctrl.load) begin
      a_nxt  = MD4_INIT_A;
      b_nxt  = MD4_INIT_B;
      c_nxt  = MD4_INIT_C;
      d_nxt  = MD4_INIT_D;
      wk_nxt = pool_word + round_const(next_step[5:4]);
    end else if (ctrl.advance) begin
      a_nxt  = d_r;
      b_nxt  = a_new;
      c_nxt  = b_r;
      d_nxt  = c_r;
      wk_nxt = pool_word + round_const(next_step[5:4]);
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    c_r  <= c_nxt;
    d_r  <= d_nxt;
    wk_r <= wk_nxt;
  end

  assign hash_a = a_r;

endmodule

[sv/entropy_seeded_lcg_generator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entropy-seeded LCG generator core
// Pseudo-random source with a 64-byte entropy pool and an MD4-based reseed.
// An entropy byte (op 0) or a draw (op 2) is taken at once, so such beats can
// arrive back to back; a draw result appears the cycle after it is taken.
// A reseed (op 1) occupies the block for a fetch step, the 48 MD4 steps run
// one per cycle through the single step unit, and the final add. The input
// is not ready while a reseed runs or while a result waits that the output
// side is not taking.
// ----------------------------------------------------------------------------
module entropy_seeded_lcg_generator_core
  import eslcg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_entropy_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [31:0] out_random_value
);

  state_t    state_r, state_nxt;
  step_t     step_r, step_nxt;
  word_t     seed_r, seed_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      accept;
  logic      pool_wr;
  md4_ctrl_t md4_ctrl;
  word_idx_t rd_idx;
  word_t     pool_word;
  word_t     hash_a;
  word_t     lcg_val;

  eslcg_pool u_pool (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (pool_wr),
    .wr_byte (in_entropy_byte),
    .rd_idx  (rd_idx),
    .rd_word (pool_word)
  );

  eslcg_md4_unit u_md4 (
    .clk       (clk),
    .ctrl      (md4_ctrl),
    .pool_word (pool_word),
    .rd_idx    (rd_idx),
    .hash_a    (hash_a)
  );

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign lcg_val  = seed_r * LCG_MUL + LCG_ADD;

  always_comb begin
    state_nxt        = state_r;
    step_nxt         = step_r;
    seed_nxt         = seed_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    pool_wr          = 1'b0;
    md4_ctrl.load    = 1'b0;
    md4_ctrl.advance = 1'b0;
    md4_ctrl.step    = step_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_ADD_ENTROPY: begin
              pool_wr = 1'b1;
            end
            OP_RESEED: begin
              md4_ctrl.load = 1'b1;
              step_nxt      = '0;
              state_nxt     = ST_HASH;
            end
            OP_NEXT: begin
              seed_nxt      = lcg_val;
              out_valid_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_HASH: begin
        md4_ctrl.advance = 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_FINISH;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_FINISH: begin
        seed_nxt      = hash_a + MD4_INIT_A;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      seed_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = seed_r;

`ifndef SYNTHESIS
  a_hash_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HASH) |-> !out_valid_r)
    else $error("result pending while reseed runs");

  a_reseed_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_RESEED) |=> (state_r == ST_HASH && step_r == '0))
    else $error("reseed did not start at step zero");

  a_hash_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HASH && step_r == LAST_STEP) |=> (state_r == ST_FINISH))
    else $error("reseed did not finish after the last step");

  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("reseed result not presented");
`endif

endmodule
